// ----- src/smpq_pkg.sv -----
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types, constants and codes of the stable min-first priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 16;
	localparam int PRIO_W       = 8;
	localparam int FILL_W       = 5;
	localparam int SLOT_W       = VALUE_W + PRIO_W;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [VALUE_W-1:0] burst_value;
		logic [PRIO_W-1:0]  prio;
	} req_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] removed_value;
		logic               was_empty;
		logic               dropped_full;
		logic [FILL_W-1:0]  fill_count;
	} rsp_item_t;

	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [VALUE_W-1:0] value;
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_SCAN,
		ST_SCAN_END,
		ST_SHIFT_INIT,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_FULL,
		RES_EMPTY,
		RES_VALUE
	} res_kind_t;

	typedef struct packed {
		logic      latch_in;
		logic      ins_write;
		logic      scan_rd;
		logic      shift_start;
		logic      shift_rd;
		logic      dec_count;
		logic      set_result;
		res_kind_t res_kind;
		logic      load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic scan_last;
		logic shift_done;
		logic rd_pending;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ----- src/stable_min_priority_queue_core.sv -----
// Insert or empty remove: the result is set in INSERT or SCAN, then loaded from FINISH.
// Remove of N entries, minimum in slot b (0 oldest): a scan of one read per cycle,
// then one read and one write per cycle for each entry after b (none if b = N - 1).
// One item at a time; the next is taken the cycle after a result loads, which waits
// while the previous result is stalled.
// Reset clears fill count, sequencer and output valid; slot RAM is not swept.
// ----------------------------------------------------------------------------
// stable_min_priority_queue_core
// Bounded min-first priority queue, stable among equal priorities.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_core import smpq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	smpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_mode (req.mode),
		.sts      (sts),
		.req_stall(req_stall),
		.cmd      (cmd)
	);

	smpq_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule

// ----- src/smpq_ram.sv -----
// ----------------------------------------------------------------------------
// smpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/smpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// smpq_ctrl
// Sequencer: dispatches insert and remove items, runs the minimum scan and
// the compaction sweep, and hands the result to the output register.
// ----------------------------------------------------------------------------
module smpq_ctrl import smpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_mode,
	input  ctrl_sts_t sts,
	output logic      req_stall,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.res_kind = RES_NONE;
		req_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch_in = 1'b1;
					state_nxt = (req_mode == MODE_INSERT) ? ST_INSERT : ST_SCAN;
				end
			end
			ST_INSERT: begin
				cmd.set_result = 1'b1;
				if (sts.count_full) begin
					cmd.res_kind = RES_FULL;
				end else begin
					cmd.ins_write = 1'b1;
					cmd.res_kind  = RES_NONE;
				end
				state_nxt = ST_FINISH;
			end
			ST_SCAN: begin
				if (sts.count_zero) begin
					cmd.set_result = 1'b1;
					cmd.res_kind   = RES_EMPTY;
					state_nxt      = ST_FINISH;
				end else begin
					cmd.scan_rd = 1'b1;
					if (sts.scan_last) begin
						state_nxt = ST_SCAN_END;
					end
				end
			end
			ST_SCAN_END: begin
				state_nxt = ST_SHIFT_INIT;
			end
			ST_SHIFT_INIT: begin
				cmd.shift_start = 1'b1;
				state_nxt = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (!sts.shift_done) begin
					cmd.shift_rd = 1'b1;
				end else if (!sts.rd_pending) begin
					cmd.dec_count  = 1'b1;
					cmd.set_result = 1'b1;
					cmd.res_kind   = RES_VALUE;
					state_nxt      = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/smpq_dp.sv -----
// ----------------------------------------------------------------------------
// smpq_dp
// Datapath: slot RAM, fill count, minimum tracker, compaction pointers and
// the result and output registers.
// ----------------------------------------------------------------------------
module smpq_dp import smpq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req,
	input  ctrl_cmd_t cmd,
	input  logic      rsp_stall,
	output ctrl_sts_t sts,
	output logic      rsp_valid,
	output rsp_item_t rsp
);

	localparam int CW = $clog2(CAPACITY);
	localparam int NW = $clog2(CAPACITY + 1);

	req_item_t          item_q;
	logic [NW-1:0]      count_q;
	logic [CW-1:0]      scan_idx_q;
	logic [NW-1:0]      sh_idx_q;
	logic               rd_valid_s1;
	logic               rd_shift_s1;
	logic [CW-1:0]      rd_idx_s1;
	logic [PRIO_W-1:0]  best_prio_q;
	logic [VALUE_W-1:0] best_value_q;
	logic [CW-1:0]      best_idx_q;
	logic [VALUE_W-1:0] res_value_q;
	logic               res_empty_q;
	logic               res_full_q;
	logic               out_valid_q;
	rsp_item_t          out_q;

	logic               ram_we;
	logic [CW-1:0]      ram_waddr;
	slot_t              ram_wdata;
	logic [CW-1:0]      ram_raddr;
	slot_t              ram_rdata;
	logic               shift_wr;

	assign shift_wr  = rd_valid_s1 && rd_shift_s1;
	assign ram_we    = cmd.ins_write || shift_wr;
	assign ram_waddr = cmd.ins_write ? count_q[CW-1:0] : (rd_idx_s1 - CW'(1));
	assign ram_wdata = cmd.ins_write ? slot_t'{prio: item_q.prio, value: item_q.burst_value}
	                                 : ram_rdata;
	assign ram_raddr = cmd.scan_rd ? scan_idx_q : sh_idx_q[CW-1:0];

	smpq_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign sts.count_zero = (count_q == '0);
	assign sts.count_full = (count_q == NW'(CAPACITY));
	assign sts.scan_last  = ((NW'(scan_idx_q) + NW'(1)) == count_q);
	assign sts.shift_done = (sh_idx_q >= count_q);
	assign sts.rd_pending = rd_valid_s1;
	assign sts.out_free   = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			item_q <= req;
		end
		if (rd_valid_s1 && !rd_shift_s1) begin
			if ((rd_idx_s1 == '0) || (ram_rdata.prio < best_prio_q)) begin
				best_prio_q  <= ram_rdata.prio;
				best_value_q <= ram_rdata.value;
				best_idx_q   <= rd_idx_s1;
			end
		end
		if (cmd.set_result) begin
			res_value_q <= (cmd.res_kind == RES_VALUE) ? best_value_q : '0;
			res_empty_q <= (cmd.res_kind == RES_EMPTY);
			res_full_q  <= (cmd.res_kind == RES_FULL);
		end
		if (cmd.load_out) begin
			out_q.removed_value <= res_value_q;
			out_q.was_empty     <= res_empty_q;
			out_q.dropped_full  <= res_full_q;
			out_q.fill_count    <= FILL_W'(count_q);
		end
		if (cmd.scan_rd || cmd.shift_rd) begin
			rd_idx_s1 <= ram_raddr;
		end
		rd_shift_s1 <= cmd.shift_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_idx_q  <= '0;
			sh_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_rd || cmd.shift_rd;
			if (cmd.ins_write) begin
				count_q <= count_q + NW'(1);
			end else if (cmd.dec_count) begin
				count_q <= count_q - NW'(1);
			end
			if (cmd.latch_in) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
			if (cmd.shift_start) begin
				sh_idx_q <= NW'(best_idx_q) + NW'(1);
			end else if (cmd.shift_rd) begin
				sh_idx_q <= sh_idx_q + NW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ----- src/smpq_checker.sv -----
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module smpq_checker import smpq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_item_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled item changed or vanished");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second item taken while busy");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.was_empty && rsp.dropped_full))
		else $error("empty and full flags together");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.was_empty |-> rsp.fill_count == '0 && rsp.removed_value == '0)
		else $error("empty remove with nonzero fields");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.dropped_full |->
			rsp.removed_value == '0 && rsp.fill_count == FILL_W'(CAPACITY))
		else $error("dropped insert with wrong fields");

endmodule

bind stable_min_priority_queue_core smpq_checker #(.CAPACITY(CAPACITY)) u_smpq_checker (.*);
